// ===== design/ldfs_pkg.sv =====
`timescale 1ns / 1ps

package ldfs_pkg;

    localparam int DISPLAY_BYTES_DEF = 16;

    localparam int ACTION_W = 2;
    localparam int OFFSET_W = 4;
    localparam int COUNT_W  = 5;
    localparam int BYTE_W   = 8;
    localparam int LEVEL_W  = 8;
    localparam int HOLD_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SEG_W    = 3;
    localparam int BIT_W    = 3;
    localparam int PHASE_W  = 2;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    localparam logic [ACTION_W-1:0] ACT_BEGIN  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BYTE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_BRIGHT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SIZE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SEQ  = 2'd2;

    localparam logic [BYTE_W-1:0] CMD_DATA     = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_ADDR     = 8'hC0;
    localparam logic [BYTE_W-1:0] CMD_DISP_OFF = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_DISP_ON  = 8'h88;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd8;

    localparam logic [HOLD_W-1:0] HOLD_ERR   = 2'd0;
    localparam logic [HOLD_W-1:0] HOLD_SHORT = 2'd1;
    localparam logic [HOLD_W-1:0] HOLD_LONG  = 2'd2;

    // What one item expands into
    typedef enum logic [2:0] {
        PLAN_ERR      = 3'd0,   // single error report
        PLAN_WR_OPEN  = 3'd1,   // start, data cmd, end, start, addr cmd
        PLAN_WR_CLOSE = 3'd2,   // as above, then end
        PLAN_DATA     = 3'd3,   // one display byte
        PLAN_DATA_END = 3'd4,   // display byte, then end
        PLAN_CTRL     = 3'd5    // start, control cmd, end
    } plan_kind_t;

    typedef enum logic [2:0] {
        SEG_START = 3'd0,
        SEG_BYTE0 = 3'd1,
        SEG_BYTE1 = 3'd2,
        SEG_END   = 3'd3,
        SEG_ERR   = 3'd4,
        SEG_NONE  = 3'd5
    } seg_kind_t;

    typedef struct packed {
        plan_kind_t          kind;
        logic [BYTE_W-1:0]   byte0;
        logic [BYTE_W-1:0]   byte1;
        logic [STATUS_W-1:0] status;
    } plan_t;

    typedef struct packed {
        logic               open;
        logic [COUNT_W-1:0] remaining;
    } frame_t;

    typedef struct packed {
        logic                clk_line;
        logic                dat_line;
        logic [HOLD_W-1:0]   hold_us;
        logic [STATUS_W-1:0] status;
        logic                last_step;
    } step_t;

    function automatic seg_kind_t seg_kind(input plan_kind_t kind, input logic [SEG_W-1:0] seg);
        seg_kind_t k;
        k = SEG_NONE;
        unique case (kind)
            PLAN_ERR:
                if (seg == 3'd0) k = SEG_ERR;
            PLAN_WR_OPEN, PLAN_WR_CLOSE:
                unique case (seg)
                    3'd0:    k = SEG_START;
                    3'd1:    k = SEG_BYTE0;
                    3'd2:    k = SEG_END;
                    3'd3:    k = SEG_START;
                    3'd4:    k = SEG_BYTE1;
                    3'd5:    k = (kind == PLAN_WR_CLOSE) ? SEG_END : SEG_NONE;
                    default: k = SEG_NONE;
                endcase
            PLAN_DATA:
                if (seg == 3'd0) k = SEG_BYTE0;
            PLAN_DATA_END:
                unique case (seg)
                    3'd0:    k = SEG_BYTE0;
                    3'd1:    k = SEG_END;
                    default: k = SEG_NONE;
                endcase
            PLAN_CTRL:
                unique case (seg)
                    3'd0:    k = SEG_START;
                    3'd1:    k = SEG_BYTE0;
                    3'd2:    k = SEG_END;
                    default: k = SEG_NONE;
                endcase
            default: k = SEG_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== design/ldfs_decode.sv =====
`timescale 1ns / 1ps

module ldfs_decode #(
    parameter int DISPLAY_BYTES = ldfs_pkg::DISPLAY_BYTES_DEF
) (
    input  logic [ldfs_pkg::ACTION_W-1:0] action,
    input  logic [ldfs_pkg::OFFSET_W-1:0] start_offset,
    input  logic [ldfs_pkg::COUNT_W-1:0]  byte_count,
    input  logic [ldfs_pkg::BYTE_W-1:0]   display_byte,
    input  logic [ldfs_pkg::LEVEL_W-1:0]  brightness_level,
    input  ldfs_pkg::frame_t              frame,
    output ldfs_pkg::plan_t               plan,
    output ldfs_pkg::frame_t              frame_next
);
    import ldfs_pkg::*;

    localparam int SUM_W = COUNT_W + 1;

    logic [SUM_W-1:0]   span;
    logic               too_big;
    logic [COUNT_W-1:0] rem_dec;
    logic [LEVEL_W-1:0] level_clamped;
    logic [BYTE_W-1:0]  ctrl_cmd;

    assign span    = SUM_W'(start_offset) + SUM_W'(byte_count);
    assign too_big = span > SUM_W'(DISPLAY_BYTES);
    assign rem_dec = frame.remaining - COUNT_W'(1);

    assign level_clamped = (brightness_level > LEVEL_MAX) ? LEVEL_MAX : brightness_level;
    assign ctrl_cmd = (level_clamped == '0) ? CMD_DISP_OFF
                    : (CMD_DISP_ON | {5'd0, 3'(level_clamped - LEVEL_W'(1))});

    always_comb
    begin
        plan.kind   = PLAN_ERR;
        plan.byte0  = CMD_DATA;
        plan.byte1  = CMD_ADDR | {4'd0, start_offset};
        plan.status = ST_SEQ;
        frame_next  = frame;
        unique case (action)
            ACT_BEGIN:
            begin
                if (frame.open)
                begin
                    plan.status = ST_SEQ;
                end
                else if (too_big)
                begin
                    plan.status = ST_SIZE;
                end
                else if (byte_count == '0)
                begin
                    plan.kind   = PLAN_WR_CLOSE;
                    plan.status = ST_OK;
                end
                else
                begin
                    plan.kind            = PLAN_WR_OPEN;
                    plan.status          = ST_OK;
                    frame_next.open      = 1'b1;
                    frame_next.remaining = byte_count;
                end
            end
            ACT_BYTE:
            begin
                if (frame.open)
                begin
                    plan.byte0           = display_byte;
                    plan.status          = ST_OK;
                    frame_next.remaining = rem_dec;
                    if (rem_dec == '0)
                    begin
                        plan.kind       = PLAN_DATA_END;
                        frame_next.open = 1'b0;
                    end
                    else
                    begin
                        plan.kind = PLAN_DATA;
                    end
                end
            end
            ACT_BRIGHT:
            begin
                if (!frame.open)
                begin
                    plan.kind   = PLAN_CTRL;
                    plan.byte0  = ctrl_cmd;
                    plan.status = ST_OK;
                end
            end
            default:
            begin
                plan.status = ST_SEQ;
            end
        endcase
    end

endmodule

// ===== design/ldfs_step_gen.sv =====
`timescale 1ns / 1ps

module ldfs_step_gen (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            plan_valid,
    input  ldfs_pkg::plan_t plan,
    output logic            plan_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output ldfs_pkg::step_t out_step
);
    import ldfs_pkg::*;

    logic               active_reg;
    plan_t              plan_reg;
    logic [SEG_W-1:0]   seg_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic               clk_level_reg;
    logic               dat_level_reg;
    logic               out_valid_reg;
    step_t              out_step_reg;

    seg_kind_t          cur_kind;
    seg_kind_t          nxt_kind;
    logic [BYTE_W-1:0]  cur_byte;
    logic               seg_done;
    logic               advance;
    logic               final_step;
    step_t              step_next;

    assign cur_kind = seg_kind(plan_reg.kind, seg_reg);
    assign nxt_kind = seg_kind(plan_reg.kind, seg_reg + SEG_W'(1));
    assign cur_byte = (cur_kind == SEG_BYTE1) ? plan_reg.byte1 : plan_reg.byte0;

    always_comb
    begin
        seg_done = 1'b0;
        step_next.clk_line = clk_level_reg;
        step_next.dat_line = dat_level_reg;
        step_next.hold_us  = HOLD_SHORT;
        step_next.status   = ST_OK;
        unique case (cur_kind)
            SEG_START:
            begin
                if (phase_reg == 2'd0)
                begin
                    step_next.dat_line = 1'b0;
                end
                else
                begin
                    step_next.clk_line = 1'b0;
                    seg_done = 1'b1;
                end
            end
            SEG_BYTE0, SEG_BYTE1:
            begin
                unique case (phase_reg)
                    2'd0:
                        step_next.dat_line = cur_byte[bit_reg];
                    2'd1:
                    begin
                        step_next.clk_line = 1'b1;
                        step_next.hold_us  = HOLD_LONG;
                    end
                    default:
                    begin
                        step_next.clk_line = 1'b0;
                        seg_done = (bit_reg == BIT_W'(BYTE_W - 1));
                    end
                endcase
            end
            SEG_END:
            begin
                unique case (phase_reg)
                    2'd0:
                        step_next.dat_line = 1'b0;
                    2'd1:
                        step_next.clk_line = 1'b1;
                    default:
                    begin
                        step_next.dat_line = 1'b1;
                        step_next.hold_us  = HOLD_LONG;
                        seg_done = 1'b1;
                    end
                endcase
            end
            SEG_ERR:
            begin
                step_next.hold_us = HOLD_ERR;
                step_next.status  = plan_reg.status;
                seg_done = 1'b1;
            end
            default:
            begin
                seg_done = 1'b1;
            end
        endcase
        step_next.last_step = seg_done && (nxt_kind == SEG_NONE);
    end

    assign advance    = active_reg && (!out_valid_reg || out_ready);
    assign final_step = advance && step_next.last_step;
    assign plan_ready = !active_reg || final_step;

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            seg_reg       <= '0;
            bit_reg       <= '0;
            phase_reg     <= '0;
            clk_level_reg <= 1'b1;
            dat_level_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                clk_level_reg <= step_next.clk_line;
                dat_level_reg <= step_next.dat_line;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (plan_valid && plan_ready)
            begin
                active_reg <= 1'b1;
                seg_reg    <= '0;
                bit_reg    <= '0;
                phase_reg  <= '0;
            end
            else if (advance)
            begin
                if (final_step)
                begin
                    active_reg <= 1'b0;
                end
                else if (seg_done)
                begin
                    seg_reg   <= seg_reg + SEG_W'(1);
                    bit_reg   <= '0;
                    phase_reg <= '0;
                end
                else if ((cur_kind == SEG_BYTE0 || cur_kind == SEG_BYTE1) && phase_reg == 2'd2)
                begin
                    bit_reg   <= bit_reg + BIT_W'(1);
                    phase_reg <= '0;
                end
                else
                begin
                    phase_reg <= phase_reg + PHASE_W'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (plan_valid && plan_ready)
        begin
            plan_reg <= plan;
        end
        if (advance)
        begin
            out_step_reg <= step_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_step  = out_step_reg;

endmodule

// ===== design/led_driver_two_wire_frame_sender_unit.sv =====
`timescale 1ns / 1ps

// Two-wire LED display driver frame sender.
//
// Slave channel (s_*): one word per request. s_tuser carries the action
// (begin write, display byte, brightness); s_tdata carries the operands.
// Master channel (m_*): one word per pin step: clock and data levels with a
// hold time in microseconds, status in m_tuser, and m_tlast on the final
// step a request causes. Errors come out as a single word with hold 0.
//
// Path: a request passes through the input register, then the plan register,
// and each of its steps then leaves through the output register.
// Throughput: one step per cycle while m_tready does not stall; a request
// expands into 1 step for an error, 24 for a display byte (27 when it closes
// the frame), 29 for brightness, 55 for a begin write (58 when the byte count
// is zero). The next request is decoded while the current one drains, so
// back-to-back requests give a gapless step stream.
//
// Reset: both pins idle high, no frame open, all buffers empty.
// A stall on m_tready freezes the sequencer; the input register then fills
// and s_tready drops until steps flow again.
module led_driver_two_wire_frame_sender_unit #(
    parameter int DISPLAY_BYTES = ldfs_pkg::DISPLAY_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [3:0] start_offset, [8:4] byte_count, [16:9] display_byte,
    // [24:17] brightness_level, [31:25] zero
    input  logic [ldfs_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] action
    input  logic [ldfs_pkg::ACTION_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] clock line level, [1] data line level, [3:2] hold_us, [7:4] zero
    output logic [ldfs_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [ldfs_pkg::STATUS_W-1:0]  m_tuser,
    output logic                           m_tlast
);
    import ldfs_pkg::*;

    // input word buffer
    logic                  in_valid_reg;
    logic [S_TDATA_W-1:0]  in_data_reg;
    logic [ACTION_W-1:0]   in_action_reg;

    // frame tracking, updated as each request is handed to the sequencer
    frame_t                frame_reg;
    frame_t                frame_next;

    plan_t                 plan;
    logic                  plan_ready;
    logic                  plan_load;
    step_t                 step;

    assign plan_load = in_valid_reg && plan_ready;
    assign s_tready  = !in_valid_reg || plan_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            frame_reg    <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (plan_load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (plan_load)
            begin
                frame_reg <= frame_next;
            end
        end
    end

    // hold the word until the sequencer takes it
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg   <= s_tdata;
            in_action_reg <= s_tuser;
        end
    end

    ldfs_decode #(
        .DISPLAY_BYTES(DISPLAY_BYTES)
    ) u_decode (
        .action           (in_action_reg),
        .start_offset     (in_data_reg[3:0]),
        .byte_count       (in_data_reg[8:4]),
        .display_byte     (in_data_reg[16:9]),
        .brightness_level (in_data_reg[24:17]),
        .frame            (frame_reg),
        .plan             (plan),
        .frame_next       (frame_next)
    );

    ldfs_step_gen u_step_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (in_valid_reg),
        .plan       (plan),
        .plan_ready (plan_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_step   (step)
    );

    assign m_tdata = {4'd0, step.hold_us, step.dat_line, step.clk_line};
    assign m_tuser = step.status;
    assign m_tlast = step.last_step;

endmodule
